/* sv/tdf_pkg.sv */
// ----------------------------------------------------------------------------
// tdf_pkg
// shared types and constants for the text header deframer
// ----------------------------------------------------------------------------
package tdf_pkg;

  // defaults for the top-level parameters
  localparam int MAX_KEYWORD_LEN_DEF = 32;
  localparam int LENGTH_BITS_DEF     = 32;

  // fixed field widths
  localparam int KW_CNT_W = 6;
  localparam int LEN_W    = 32;

  // character codes
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;

  // result kinds
  typedef enum logic [1:0] {
    KIND_KEY = 2'd0,
    KIND_HDR = 2'd1,
    KIND_PAY = 2'd2,
    KIND_ERR = 2'd3
  } kind_t;

  // error codes
  typedef enum logic [1:0] {
    ERR_LEN   = 2'd0,
    ERR_TERM  = 2'd1,
    ERR_KWLEN = 2'd2
  } err_t;

  // header parse position, one-hot
  typedef enum logic [7:0] {
    PH_SKIP_VER = 8'b0000_0001,
    PH_VER      = 8'b0000_0010,
    PH_SKIP_KW  = 8'b0000_0100,
    PH_KW       = 8'b0000_1000,
    PH_SKIP_LEN = 8'b0001_0000,
    PH_LEN      = 8'b0010_0000,
    PH_TERM     = 8'b0100_0000,
    PH_LF       = 8'b1000_0000
  } phase_t;

  // one parsed result
  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] length;
    logic             last;
    err_t             code;
  } res_t;

endpackage

/* sv/text_header_deframer.sv */
// ----------------------------------------------------------------------------
// text_header_deframer
// splits a byte stream of text-framed messages into keyword, header, error and payload
// ----------------------------------------------------------------------------
// the result of an input transaction is registered and appears on the out_ side in the cycle after it
// throughput: one input byte per cycle, set by the combinational per-byte parser feeding
//   the output register; input stalls only while a held result is not taken
// reset (synchronous, rst_n low): parser returns to skipping before a version
//   word, counters cleared, output register emptied
module text_header_deframer #(
  parameter int MAX_KEYWORD_LEN = tdf_pkg::MAX_KEYWORD_LEN_DEF,
  parameter int LENGTH_BITS     = tdf_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] out_byte, [39:8] data_length,
                                  // [41:40] error_code, [47:42] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last payload byte or empty header
);
  import tdf_pkg::*;

  logic in_acc;
  res_t res;
  res_t res_r;
  logic out_valid_r, out_valid_nxt;

  // a new byte is taken whenever the output register is free or drains now
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // parse state and per-byte decision
  tdf_parser #(
    .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN),
    .LENGTH_BITS    (LENGTH_BITS)
  ) u_parser (
    .clk  (clk),
    .rst_n(rst_n),
    .step (in_acc),
    .din  (in_tdata),
    .res  (res)
  );

  // output register: loads on every accepted byte, bytes with no result leave it empty
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = res.valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, res_r.code, res_r.length, res_r.data};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;

`ifndef SYNTHESIS
  // header complete marks last exactly when the declared length is zero
  a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_HDR |-> out_tlast == (out_tdata[39:8] == '0))
    else $error("header last flag does not match zero length");

  // errors carry no byte, no length and a defined code
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ERR |->
      out_tdata[39:0] == '0 && !out_tlast && out_tdata[41:40] != 2'd3)
    else $error("error result carries stray fields");

  // keyword bytes never carry last or a length
  a_key_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_KEY |-> !out_tlast && out_tdata[41:8] == '0)
    else $error("keyword result carries stray fields");

  // a result not taken stays in place while new input is held off
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && !$past(in_acc))
    else $error("output register overwritten while stalled");
`endif

endmodule

/* sv/tdf_parser.sv */
// ----------------------------------------------------------------------------
// tdf_parser
// header parse state and combinational byte classification
// ----------------------------------------------------------------------------
module tdf_parser #(
  parameter int MAX_KEYWORD_LEN = tdf_pkg::MAX_KEYWORD_LEN_DEF,
  parameter int LENGTH_BITS     = tdf_pkg::LENGTH_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    din,
  output tdf_pkg::res_t res
);
  import tdf_pkg::*;

  localparam int ACC_W = LENGTH_BITS + 4;
  localparam logic [KW_CNT_W-1:0] KW_MAX = KW_CNT_W'(MAX_KEYWORD_LEN);

  phase_t                  phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0]  accum_r, accum_nxt;
  logic [LENGTH_BITS-1:0]  left_r, left_nxt;
  logic [KW_CNT_W-1:0]     kw_cnt_r, kw_cnt_nxt;

  logic                    is_sp;
  logic                    is_dig;
  logic [ACC_W-1:0]        acc_base;
  logic [ACC_W-1:0]        acc_sum;
  logic                    acc_ovf;
  logic                    fail;
  err_t                    fail_code;

  always_comb begin
    is_sp    = din inside {CH_SP, CH_TAB, CH_CR, CH_LF};
    is_dig   = din inside {[CH_0:CH_9]};
    // first digit starts from zero
    acc_base = (phase_r == PH_LEN) ? ACC_W'(accum_r) : '0;
    acc_sum  = (acc_base << 3) + (acc_base << 1) + ACC_W'(din - CH_0);
    acc_ovf  = |acc_sum[ACC_W-1:LENGTH_BITS];
  end

  always_comb begin
    phase_nxt  = phase_r;
    accum_nxt  = accum_r;
    left_nxt   = left_r;
    kw_cnt_nxt = kw_cnt_r;
    fail       = 1'b0;
    fail_code  = ERR_LEN;
    res        = '0;

    if (left_r != '0) begin
      // payload bytes pass through regardless of phase
      left_nxt   = left_r - 1'b1;
      res.valid  = 1'b1;
      res.kind   = KIND_PAY;
      res.data   = din;
      res.last   = (left_r == LENGTH_BITS'(1));
    end else begin
      case (phase_r)
        PH_SKIP_VER: begin
          if (!is_sp) phase_nxt = PH_VER;
        end
        PH_VER: begin
          if (is_sp) phase_nxt = PH_SKIP_KW;
        end
        PH_SKIP_KW, PH_KW: begin
          if (is_sp) begin
            if (phase_r == PH_KW) phase_nxt = PH_SKIP_LEN;
          end else if (kw_cnt_r >= KW_MAX) begin
            fail      = 1'b1;
            fail_code = ERR_KWLEN;
          end else begin
            kw_cnt_nxt = kw_cnt_r + 1'b1;
            phase_nxt  = PH_KW;
            res.valid  = 1'b1;
            res.kind   = KIND_KEY;
            res.data   = din;
          end
        end
        PH_SKIP_LEN, PH_LEN: begin
          if (is_sp) begin
            if (phase_r == PH_LEN) begin
              if (din == CH_CR) begin
                phase_nxt = PH_LF;
              end else if (din == CH_LF) begin
                fail      = 1'b1;
                fail_code = ERR_TERM;
              end else begin
                phase_nxt = PH_TERM;
              end
            end
          end else if (!is_dig || acc_ovf) begin
            fail      = 1'b1;
            fail_code = ERR_LEN;
          end else begin
            accum_nxt = acc_sum[LENGTH_BITS-1:0];
            phase_nxt = PH_LEN;
          end
        end
        PH_TERM: begin
          if (din == CH_CR) begin
            phase_nxt = PH_LF;
          end else if (din != CH_SP && din != CH_TAB) begin
            fail      = 1'b1;
            fail_code = ERR_TERM;
          end
        end
        PH_LF: begin
          if (din != CH_LF) begin
            fail      = 1'b1;
            fail_code = ERR_TERM;
          end else begin
            left_nxt   = accum_r;
            phase_nxt  = PH_SKIP_VER;
            accum_nxt  = '0;
            kw_cnt_nxt = '0;
            res.valid  = 1'b1;
            res.kind   = KIND_HDR;
            res.length = LEN_W'(accum_r);
            res.last   = (accum_r == '0);
          end
        end
        default: begin
          phase_nxt = PH_SKIP_VER;
        end
      endcase

      if (fail) begin
        phase_nxt  = PH_SKIP_VER;
        accum_nxt  = '0;
        kw_cnt_nxt = '0;
        res        = '0;
        res.valid  = 1'b1;
        res.kind   = KIND_ERR;
        res.code   = fail_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SKIP_VER;
      accum_r  <= '0;
      left_r   <= '0;
      kw_cnt_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      accum_r  <= accum_nxt;
      left_r   <= left_nxt;
      kw_cnt_r <= kw_cnt_nxt;
    end
  end

endmodule
